@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by interval_track_assignment. Each macro checks on the
// rising clock edge and stays quiet while the synchronous active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ITRK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ITRK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/itrk_pkg.sv @@
// ----------------------------------------------------------------------------
// itrk_pkg
// Shared types and defaults of the interval track assignment block.
// ----------------------------------------------------------------------------
package itrk_pkg;

    // Defaults of the top-level parameters
    localparam int unsigned MAX_INTERVALS_DEF = 1024;
    localparam int unsigned COORD_BITS_DEF    = 32;

    // Fixed field widths of the item payloads
    localparam int unsigned COORD_W = 32;
    localparam int unsigned TRACK_W = 10;

    // Input item: one closed interval
    typedef struct packed {
        logic [COORD_W-1:0] interval_start;
        logic [COORD_W-1:0] interval_end;
        logic               first_of_set;
    } t_itrk_in;

    // Result item: assigned track and set-full flag
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               overflow;
    } t_itrk_out;

endpackage

@@ rtl/itrk_ram.sv @@
// ----------------------------------------------------------------------------
// itrk_ram
// Generic single-write, single-read RAM with registered read data. A read of
// the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module itrk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/interval_track_assignment.sv @@
// ----------------------------------------------------------------------------
// interval_track_assignment
// First-fit track assignment for closed intervals.
//
// Input channel (i_in_valid / o_in_ready / i_in) carries one interval per
// item; output channel (o_out_valid / i_out_ready / o_out) returns one result
// item per input item, in order. Each interval is checked against the n
// intervals stored for the current set by one shared overlap comparator, one
// stored interval per cycle out of the entry RAM, and then the busy-track RAM
// is walked one track per cycle for the lowest free track, with n up to
// MAX_INTERVALS - 1. An item that finds the set full skips the scan and the
// search. The block returns to idle and can accept the next item in the cycle
// after the result is loaded. One item is worked on at a time.
// After reset the block runs a clearing pass over the busy-track RAM with
// o_in_ready low. The result sits in an output register: the next item is
// accepted while it waits, and a stalled receiver only holds the block at the
// end of the following item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_track_assignment #(
    parameter int unsigned MAX_INTERVALS = itrk_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned COORD_BITS    = itrk_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itrk_pkg::t_itrk_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itrk_pkg::t_itrk_out o_out
);

    localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned ENT_W = 2 * COORD_BITS + IDX_W;
    localparam int unsigned TRK_W = itrk_pkg::TRACK_W;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_INTERVALS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_INTERVALS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_FINISH
    } t_state;

    // Control registers
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_v1, n_v1;
    logic             r_v2, n_v2;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;

    // Payload registers
    logic [COORD_BITS-1:0] r_s, n_s;
    logic [COORD_BITS-1:0] r_e, n_e;
    logic [IDX_W-1:0]      r_htrk, n_htrk;
    logic [IDX_W-1:0]      r_sidx, n_sidx;
    logic [IDX_W-1:0]      r_t, n_t;
    itrk_pkg::t_itrk_out   r_out, n_out;

    // Memory ports
    logic             ent_we;
    logic [ENT_W-1:0] ent_wdata;
    logic [ENT_W-1:0] ent_rdata;
    logic             bsy_we;
    logic [IDX_W-1:0] bsy_waddr;
    logic             bsy_wdata;
    logic             bsy_rdata;

    logic [COORD_BITS-1:0] ent_start;
    logic [COORD_BITS-1:0] ent_end;
    logic [IDX_W-1:0]      ent_track;
    logic                  in_fire;
    logic                  out_free;
    logic                  issue;
    logic                  hit;
    logic                  load;
    logic [IDX_W-1:0]      t_sel;

    // Stored intervals: start, end and track packed in one entry
    itrk_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_INTERVALS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_n[IDX_W-1:0]),
        .i_wdata (ent_wdata),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (ent_rdata)
    );

    // Busy-track marks, all zero between items
    itrk_ram #(
        .WIDTH (1),
        .DEPTH (MAX_INTERVALS)
    ) u_bsy_ram (
        .i_clk   (i_clk),
        .i_we    (bsy_we),
        .i_waddr (bsy_waddr),
        .i_wdata (bsy_wdata),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (bsy_rdata)
    );

    assign ent_start = ent_rdata[ENT_W-1 -: COORD_BITS];
    assign ent_end   = ent_rdata[IDX_W +: COORD_BITS];
    assign ent_track = ent_rdata[IDX_W-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign issue       = (r_k < r_n);
    assign hit         = (ent_end >= r_s) && (r_e >= ent_start);
    assign t_sel       = r_found ? r_t : r_n[IDX_W-1:0];
    assign load        = (r_state == S_FINISH) && out_free;
    assign ent_wdata   = {r_s, r_e, t_sel};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer and next-state logic
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_n         = r_n;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_v1        = 1'b0;
        n_v2        = 1'b0;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_s         = r_s;
        n_e         = r_e;
        n_htrk      = r_htrk;
        n_sidx      = r_sidx;
        n_t         = r_t;
        n_out       = r_out;
        ent_we      = 1'b0;
        bsy_we      = 1'b0;
        bsy_waddr   = r_k[IDX_W-1:0];
        bsy_wdata   = 1'b0;

        // Drop the result once taken, load a new one at the end of an item
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid    = 1'b1;
            n_out.track    = r_ovf ? '0 : TRK_W'(t_sel);
            n_out.overflow = r_ovf;
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep the busy RAM to zero after reset
                bsy_we = 1'b1;
                if (r_k == LAST_CNT) begin
                    n_state = S_IDLE;
                    n_k     = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_s     = COORD_BITS'(i_in.interval_start);
                    n_e     = COORD_BITS'(i_in.interval_end);
                    n_found = 1'b0;
                    n_k     = '0;
                    n_n     = i_in.first_of_set ? '0 : r_count;
                    n_ovf   = !i_in.first_of_set && (r_count == MAX_CNT);
                    n_state = n_ovf ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                // Compare against one stored interval a cycle, mark hit tracks
                if (issue) begin
                    n_k = r_k + 1'b1;
                end
                n_v1      = issue;
                n_v2      = r_v1 && hit;
                n_htrk    = ent_track;
                bsy_we    = r_v2;
                bsy_waddr = r_htrk;
                bsy_wdata = 1'b1;
                if (!issue && !r_v1 && !r_v2) begin
                    n_state = S_SEARCH;
                    n_k     = '0;
                end
            end
            S_SEARCH: begin
                // Walk the marks for the lowest free track, clearing as we go
                bsy_we = issue;
                if (issue) begin
                    n_k = r_k + 1'b1;
                end
                n_v1   = issue;
                n_sidx = r_k[IDX_W-1:0];
                if (r_v1 && !bsy_rdata && !r_found) begin
                    n_found = 1'b1;
                    n_t     = r_sidx;
                end
                if (!issue && !r_v1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Store the interval unless the set is full, and hand over the result
                if (out_free) begin
                    n_state = S_IDLE;
                    if (!r_ovf) begin
                        ent_we  = 1'b1;
                        n_count = r_n + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_n         <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_n         <= n_n;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_e    <= n_e;
        r_htrk <= n_htrk;
        r_sidx <= n_sidx;
        r_t    <= n_t;
        r_out  <= n_out;
    end

    // Checks
    `ITRK_ASSERT_IMPL(a_ovf_track_zero, i_clk, i_rst_n,
        o_out_valid && o_out.overflow, o_out.track == '0,
        "overflow result with nonzero track")
    `ITRK_ASSERT_IMPL(a_track_bound, i_clk, i_rst_n,
        load && !r_ovf, CNT_W'(t_sel) <= r_n,
        "track above stored count")
    `ITRK_ASSERT_IMPL(a_store_in_range, i_clk, i_rst_n,
        ent_we, r_n < MAX_CNT,
        "store write beyond capacity")
    `ITRK_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        in_fire, !o_in_ready,
        "ready right after accept")

endmodule
